// ===== design/mpeg_frame_packet_segmenter_assert.svh =====
// ----------------------------------------------------------------------------
// mpeg_frame_packet_segmenter_assert
// assertion macros shared by the queue and back modules
// ----------------------------------------------------------------------------
`ifndef MPEG_FRAME_PACKET_SEGMENTER_ASSERT_SVH
`define MPEG_FRAME_PACKET_SEGMENTER_ASSERT_SVH

// same-cycle implication
`define MFPS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// next-cycle implication
`define MFPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

// ===== design/mfps_pkg.sv =====
// ----------------------------------------------------------------------------
// mfps_pkg
// types and constants of the frame packet segmenter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfps_pkg;

    localparam int SLICE_BYTES = 64;
    localparam int MAX_PACKETS = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam int ROOM_W = 14;
    localparam int CNT_W  = $clog2(MAX_PACKETS + 1);

    typedef enum logic [2:0] {
        CFG_MTU       = 3'd0,
        CFG_HEADER    = 3'd1,
        CFG_KIND      = 3'd2,
        CFG_SOURCE    = 3'd3,
        CFG_BASE      = 3'd4,
        CFG_DELAY     = 3'd5,
        CFG_TICKS     = 3'd6,
        CFG_FIRST_SEQ = 3'd7
    } cfg_index_t;

    typedef enum logic [2:0] {
        PIC_UNKNOWN = 3'd0,
        PIC_I       = 3'd1,
        PIC_P       = 3'd2,
        PIC_B       = 3'd3,
        PIC_D       = 3'd4
    } pic_code_t;

    typedef struct packed {
        logic [ROOM_W-1:0] mtu_bytes;
        logic [6:0]        header_bytes;
        logic [6:0]        payload_kind;
        logic [31:0]       source_id;
        logic [31:0]       stamp_base;
        logic [31:0]       delay_ticks;
        logic [31:0]       frame_ticks_q16;
    } cfg_t;

    typedef struct packed {
        logic [15:0] bytes;
        logic [2:0]  code;
        logic [31:0] stamp;
    } frame_desc_t;

    typedef struct packed {
        logic [15:0] payload_bytes;
        logic [2:0]  picture_code;
        logic        marker;
        logic [15:0] sequence_number;
        logic [31:0] timestamp;
        logic [31:0] source_out;
        logic [6:0]  payload_type_out;
    } pkt_t;

    typedef struct packed {
        logic        load;
        logic [15:0] value;
    } seq_load_t;

endpackage

// ===== design/mpeg_frame_packet_segmenter.sv =====
// ----------------------------------------------------------------------------
// mpeg_frame_packet_segmenter
// splits video frame descriptors into timestamped packet descriptors
// ----------------------------------------------------------------------------
// One frame transaction in, one packet transaction out per packet. The front
// takes a frame whenever the two-entry frame queue has room; the back
// sequencer fetches a frame from the queue in its idle state and then emits
// one packet per cycle while the output is not stalled; a frame yields at most
// 64 packets. Frames under one byte yield no packets but still advance the
// frame clock. Configuration writes take effect at once and are meant to be
// made while the block is idle.
`timescale 1ns / 1ps

module mpeg_frame_packet_segmenter import mfps_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // frame_bits[18:0], zero pad
    input  logic [7:0]   s_tuser,   // type_letter[7:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    // payload_bytes[15:0], sequence_number[31:16], timestamp[63:32],
    // source_out[95:64], payload_type_out[102:96], zero pad
    output logic [103:0] m_tdata,
    output logic [2:0]   m_tuser,   // picture_code[2:0]
    output logic         m_tlast
);

    cfg_t        cfg_reg, cfg_next;
    seq_load_t   seq_load;
    frame_desc_t q_in, q_head;
    logic        q_push, q_pop, q_full, q_empty;
    pkt_t        pkt;

    always_comb begin
        cfg_next       = cfg_reg;
        seq_load.load  = 1'b0;
        seq_load.value = cfg_data[15:0];
        if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MTU:       cfg_next.mtu_bytes       = cfg_data[ROOM_W-1:0];
                CFG_HEADER:    cfg_next.header_bytes    = cfg_data[6:0];
                CFG_KIND:      cfg_next.payload_kind    = cfg_data[6:0];
                CFG_SOURCE:    cfg_next.source_id       = cfg_data;
                CFG_BASE:      cfg_next.stamp_base      = cfg_data;
                CFG_DELAY:     cfg_next.delay_ticks     = cfg_data;
                CFG_TICKS:     cfg_next.frame_ticks_q16 = cfg_data;
                CFG_FIRST_SEQ: seq_load.load            = 1'b1;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mtu_bytes       <= ROOM_W'(1500);
            cfg_reg.header_bytes    <= 7'd16;
            cfg_reg.payload_kind    <= 7'd32;
            cfg_reg.source_id       <= '0;
            cfg_reg.stamp_base      <= '0;
            cfg_reg.delay_ticks     <= '0;
            cfg_reg.frame_ticks_q16 <= 32'd235929600;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    mfps_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .frame_bits  (s_tdata[18:0]),
        .type_letter (s_tuser),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    mfps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    mfps_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .seq_load (seq_load),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .pkt      (pkt)
    );

    assign m_tdata = {1'b0, pkt.payload_type_out, pkt.source_out, pkt.timestamp,
                      pkt.sequence_number, pkt.payload_bytes};
    assign m_tuser = pkt.picture_code;
    assign m_tlast = pkt.marker;

endmodule

// ===== design/mfps_front.sv =====
// ----------------------------------------------------------------------------
// mfps_front
// accepts frame transactions, maps the picture type and stamps the frame
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfps_front import mfps_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [18:0] frame_bits,
    input  logic [7:0]  type_letter,
    input  logic        q_full,
    output logic        q_push,
    output frame_desc_t q_data
);

    logic [47:0] acc_reg, acc_next;
    logic        accept;

    function automatic logic [2:0] picture_of(input logic [7:0] letter);
        logic [2:0] code;
        unique case (letter)
            8'h49:   code = PIC_I;
            8'h50:   code = PIC_P;
            8'h42:   code = PIC_B;
            8'h44:   code = PIC_D;
            default: code = PIC_UNKNOWN;
        endcase
        return code;
    endfunction

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        q_data.bytes = frame_bits[18:3];
        q_data.code  = picture_of(type_letter);
        q_data.stamp = cfg.stamp_base + cfg.delay_ticks + acc_reg[47:16];
        q_push       = accept && (frame_bits[18:3] != 16'd0);
        acc_next     = accept ? acc_reg + {16'd0, cfg.frame_ticks_q16} : acc_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

endmodule

// ===== design/mfps_queue.sv =====
// ----------------------------------------------------------------------------
// mfps_queue
// short frame descriptor queue between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mpeg_frame_packet_segmenter_assert.svh"

module mfps_queue import mfps_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  frame_desc_t push_data,
    input  logic        pop,
    output frame_desc_t head,
    output logic        full,
    output logic        empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);

    frame_desc_t        mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W_Q-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign full  = (count_reg == CNT_W_Q'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + CNT_W_Q'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W_Q'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `MFPS_ASSERT_IMPL(a_no_push_full, aclk, aresetn, full, !push)
    `MFPS_ASSERT_IMPL(a_no_pop_empty, aclk, aresetn, empty, !pop)
    `MFPS_ASSERT_NEXT(a_count_up, aclk, aresetn, push && !pop, count_reg == $past(count_reg) + CNT_W_Q'(1))

endmodule

// ===== design/mfps_back.sv =====
// ----------------------------------------------------------------------------
// mfps_back
// cuts one queued frame into packet transactions, one per cycle while the output is not stalled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "mpeg_frame_packet_segmenter_assert.svh"

module mfps_back import mfps_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  seq_load_t   seq_load,
    input  logic        q_empty,
    input  frame_desc_t q_head,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output pkt_t        pkt
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SEND = 2'b10
    } state_t;

    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_PACKETS - 1);

    state_t            state_reg, state_next;
    logic [15:0]       left_reg, left_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [2:0]        code_reg, code_next;
    logic [31:0]       stamp_reg, stamp_next;
    logic [15:0]       seq_reg, seq_next;
    logic              valid_reg, valid_next;
    pkt_t              pkt_reg, pkt_next;

    logic [ROOM_W-1:0] room, slice;
    logic              out_free, take_slice, mark;
    logic [15:0]       size;

    always_comb begin
        room       = (cfg.mtu_bytes > {7'd0, cfg.header_bytes})
                   ? cfg.mtu_bytes - {7'd0, cfg.header_bytes} : '0;
        slice      = ROOM_W'(room / SLICE_BYTES * SLICE_BYTES);
        take_slice = (left_reg > {2'd0, room}) && (slice != '0) && (count_reg != LAST_CNT);
        size       = take_slice ? {2'd0, slice} : left_reg;
        mark       = !take_slice;
        out_free   = !valid_reg || m_tready;
    end

    always_comb begin
        state_next = state_reg;
        left_next  = left_reg;
        count_next = count_reg;
        code_next  = code_reg;
        stamp_next = stamp_reg;
        seq_next   = seq_reg;
        valid_next = valid_reg && !m_tready;
        pkt_next   = pkt_reg;
        q_pop      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                priority if (seq_load.load) begin
                    seq_next = seq_load.value;
                end else if (!q_empty) begin
                    q_pop      = 1'b1;
                    left_next  = q_head.bytes;
                    code_next  = q_head.code;
                    stamp_next = q_head.stamp;
                    count_next = '0;
                    state_next = ST_SEND;
                end
            end
            ST_SEND: begin
                if (out_free) begin
                    valid_next                = 1'b1;
                    pkt_next.payload_bytes    = size;
                    pkt_next.picture_code     = code_reg;
                    pkt_next.marker           = mark;
                    pkt_next.sequence_number  = seq_reg;
                    pkt_next.timestamp        = stamp_reg;
                    pkt_next.source_out       = cfg.source_id;
                    pkt_next.payload_type_out = cfg.payload_kind;
                    left_next                 = left_reg - size;
                    count_next                = count_reg + CNT_W'(1);
                    seq_next                  = seq_reg + 16'd1;
                    if (mark) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        left_reg  <= left_next;
        count_reg <= count_next;
        code_reg  <= code_next;
        stamp_reg <= stamp_next;
        pkt_reg   <= pkt_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            seq_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            seq_reg   <= seq_next;
            valid_reg <= valid_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign pkt      = pkt_reg;

    `MFPS_ASSERT_IMPL(a_last_marks, aclk, aresetn, (state_reg == ST_SEND) && (count_reg == LAST_CNT), mark)
    `MFPS_ASSERT_IMPL(a_no_pop_busy, aclk, aresetn, state_reg == ST_SEND, !q_pop)
    `MFPS_ASSERT_NEXT(a_seq_step, aclk, aresetn, (state_reg == ST_SEND) && out_free, seq_reg == $past(seq_reg) + 16'd1)

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the frame packet segmenter
// ----------------------------------------------------------------------------
// Frames are pushed in on the s_ stream and packet descriptors are collected
// on the m_ stream. A short table of hand-picked frames and register writes
// comes first, then random phases with fresh register settings. Every packet
// is compared field by field with its table entry or an in-bench prediction.
// Both streams idle at random; the receiver holds off once for a long stretch
// and the sender pauses once mid-phase until the block has drained.
`timescale 1ns / 1ps

module tb;
    import mfps_pkg::*;

    localparam int LIMIT            = 1_000_000;
    localparam int HOLD_CYCLES      = 400;
    localparam int SETTLE_CYCLES    = 16;
    localparam int TAIL_CYCLES      = 80;
    localparam int RANDOM_PHASES    = 8;
    localparam int FRAMES_PER_PHASE = 52;
    localparam int PLAN_ROWS        = 38;
    localparam int MTU_LOW          = 1100;
    localparam int MTU_HIGH         = 9216;
    localparam int HEADER_HIGH      = 64;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_ONE,
        ROW_NONE,
        ROW_CFG
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic [18:0] bits;
        logic [7:0]  letter;
        cfg_index_t  idx;
        logic [31:0] value;
        pkt_t        pkt;
    } row_t;

    typedef struct {
        row_kind_t kind;
        pkt_t      pkt;
    } frame_note_t;

    localparam pkt_t NO_PKT = '0;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         cfg_we    = 1'b0;
    cfg_index_t   cfg_index = CFG_MTU;
    logic [31:0]  cfg_data  = '0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [23:0]  s_tdata   = '0;   // frame_bits[18:0], zero pad
    logic [7:0]   s_tuser   = '0;   // type_letter[7:0]
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    // payload_bytes[15:0], sequence_number[31:16], timestamp[63:32],
    // source_out[95:64], payload_type_out[102:96], zero pad
    logic [103:0] m_tdata;
    logic [2:0]   m_tuser;          // picture_code[2:0]
    logic         m_tlast;

    mpeg_frame_packet_segmenter u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    cfg_t        cfg_mirror;
    logic [15:0] next_seq;
    logic [47:0] frame_clock;

    pkt_t        packet_expect_q[$];
    frame_note_t frame_note_q[$];

    int errors        = 0;
    int frames_in     = 0;
    int packets_out   = 0;
    int cfg_writes    = 0;
    int empty_frames  = 0;
    int full_frames   = 0;
    int cycles        = 0;
    int tx_gap_max    = 5;
    int rx_gap_max    = 5;
    int hold_requests = 0;
    int holds_done    = 0;

    row_t plan [PLAN_ROWS] = '{
        '{ROW_ONE,     19'd800,    "I",   CFG_MTU, 32'd0,
          '{16'd100, PIC_I, 1'b1, 16'd0, 32'd0, 32'd0, 7'd32}},
        '{ROW_NONE,    19'd7,      "P",   CFG_MTU, 32'd0, NO_PKT},
        '{ROW_ONE,     19'd8,      "B",   CFG_MTU, 32'd0,
          '{16'd1, PIC_B, 1'b1, 16'd1, 32'd7200, 32'd0, 7'd32}},
        '{ROW_NONE,    19'd0,      "D",   CFG_MTU, 32'd0, NO_PKT},
        '{ROW_ONE,     19'd11872,  "D",   CFG_MTU, 32'd0,
          '{16'd1484, PIC_D, 1'b1, 16'd2, 32'd14400, 32'd0, 7'd32}},
        '{ROW_ONE,     19'd15,     8'h00, CFG_MTU, 32'd0,
          '{16'd1, PIC_UNKNOWN, 1'b1, 16'd3, 32'd18000, 32'd0, 7'd32}},
        '{ROW_PREDICT, 19'd11880,  "X",   CFG_MTU, 32'd0, NO_PKT},
        '{ROW_PREDICT, 19'd524287, 8'hFF, CFG_MTU, 32'd0, NO_PKT},
        '{ROW_PREDICT, 19'd524280, "i",   CFG_MTU, 32'd0, NO_PKT},
        // sequence wrap, timestamp wrap, widest room
        '{ROW_CFG,     19'd0,      8'h00, CFG_FIRST_SEQ, 32'hFFFF_FFFE, NO_PKT},
        '{ROW_CFG,     19'd0,      8'h00, CFG_SOURCE,    32'hFFFF_FFFF, NO_PKT},
        '{ROW_CFG,     19'd0,      8'h00, CFG_KIND,      32'hFFFF_FFFF, NO_PKT},
        '{ROW_CFG,     19'd0,      8'h00, CFG_BASE,      32'hFFFF_FFFF, NO_PKT},
        '{ROW_CFG,     19'd0,      8'h00, CFG_DELAY,     32'hFFFF_FFFF, NO_PKT},
        '{ROW_CFG,     19'd0,      8'h00, CFG_TICKS,     32'hFFFF_FFFF, NO_PKT},
        '{ROW_CFG,     19'd0,      8'h00, CFG_MTU,       32'h0000_3FFF, NO_PKT},
        '{ROW_CFG,     19'd0,      8'h00, CFG_HEADER,    32'h0000_0000, NO_PKT},
        '{ROW_PREDICT, 19'd524287, "P",   CFG_MTU, 32'd0, NO_PKT},
        '{ROW_PREDICT, 19'd300000, "B",   CFG_MTU, 32'd0, NO_PKT},
        // packet count cap
        '{ROW_CFG,     19'd0,      8'h00, CFG_MTU,       32'd1000, NO_PKT},
        '{ROW_PREDICT, 19'd524287, "I",   CFG_MTU, 32'd0, NO_PKT},
        // header larger than mtu
        '{ROW_CFG,     19'd0,      8'h00, CFG_HEADER,    32'd64, NO_PKT},
        '{ROW_CFG,     19'd0,      8'h00, CFG_MTU,       32'd10, NO_PKT},
        '{ROW_PREDICT, 19'd524287, "D",   CFG_MTU, 32'd0, NO_PKT},
        // room under one slice
        '{ROW_CFG,     19'd0,      8'h00, CFG_MTU,       32'd127, NO_PKT},
        '{ROW_PREDICT, 19'd8000,   "P",   CFG_MTU, 32'd0, NO_PKT},
        '{ROW_CFG,     19'd0,      8'h00, CFG_MTU,       32'd1100, NO_PKT},
        '{ROW_PREDICT, 19'd524287, "B",   CFG_MTU, 32'd0, NO_PKT},
        '{ROW_CFG,     19'd0,      8'h00, CFG_TICKS,     32'd0, NO_PKT},
        '{ROW_CFG,     19'd0,      8'h00, CFG_SOURCE,    32'd0, NO_PKT},
        '{ROW_CFG,     19'd0,      8'h00, CFG_KIND,      32'd0, NO_PKT},
        '{ROW_CFG,     19'd0,      8'h00, CFG_BASE,      32'd0, NO_PKT},
        '{ROW_CFG,     19'd0,      8'h00, CFG_DELAY,     32'd0, NO_PKT},
        '{ROW_CFG,     19'd0,      8'h00, CFG_FIRST_SEQ, 32'd0, NO_PKT},
        '{ROW_CFG,     19'd0,      8'h00, CFG_MTU,       32'd9216, NO_PKT},
        '{ROW_CFG,     19'd0,      8'h00, CFG_HEADER,    32'd16, NO_PKT},
        '{ROW_PREDICT, 19'd524287, "I",   CFG_MTU, 32'd0, NO_PKT},
        '{ROW_PREDICT, 19'd16,     "P",   CFG_MTU, 32'd0, NO_PKT}
    };

    function automatic pic_code_t picture_of_letter(input logic [7:0] letter);
        case (letter)
            "I": return PIC_I;
            "P": return PIC_P;
            "B": return PIC_B;
            "D": return PIC_D;
            default: return PIC_UNKNOWN;
        endcase
    endfunction

    task automatic segment_frame(input logic [18:0] bits, input logic [7:0] letter,
                                 ref pkt_t pkts[$]);
        logic [15:0] left;
        logic [15:0] room;
        logic [15:0] slice;
        logic [15:0] size;
        logic [31:0] stamp;
        pic_code_t   code;
        pkt_t        pkt;
        int          count;
        pkts.delete();
        code  = picture_of_letter(letter);
        left  = 16'(bits[18:3]);
        room  = (16'(cfg_mirror.mtu_bytes) > 16'(cfg_mirror.header_bytes)) ?
                16'(cfg_mirror.mtu_bytes) - 16'(cfg_mirror.header_bytes) : 16'd0;
        slice = room & ~16'(SLICE_BYTES - 1);
        stamp = cfg_mirror.stamp_base + cfg_mirror.delay_ticks + frame_clock[47:16];
        count = 0;
        while (left != 16'd0 && count < MAX_PACKETS) begin
            if (left > room && slice != 16'd0 && count < MAX_PACKETS - 1) begin
                size       = slice;
                pkt.marker = 1'b0;
            end else begin
                size       = left;
                pkt.marker = 1'b1;
            end
            left                 = left - size;
            pkt.payload_bytes    = size;
            pkt.picture_code     = code;
            pkt.sequence_number  = next_seq;
            pkt.timestamp        = stamp;
            pkt.source_out       = cfg_mirror.source_id;
            pkt.payload_type_out = cfg_mirror.payload_kind;
            pkts.push_back(pkt);
            next_seq = next_seq + 16'd1;
            count++;
        end
        frame_clock = frame_clock + 48'(cfg_mirror.frame_ticks_q16);
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // predictor and checker
    always @(posedge aclk) begin : monitor
        pkt_t        frame_pkts[$];
        frame_note_t note;
        pkt_t        want;
        if (!aresetn) begin
            cfg_mirror.mtu_bytes       = 14'd1500;
            cfg_mirror.header_bytes    = 7'd16;
            cfg_mirror.payload_kind    = 7'd32;
            cfg_mirror.source_id       = '0;
            cfg_mirror.stamp_base      = '0;
            cfg_mirror.delay_ticks     = '0;
            cfg_mirror.frame_ticks_q16 = 32'd235929600;
            next_seq                   = '0;
            frame_clock                = '0;
        end else begin
            if (cfg_we) begin
                cfg_writes++;
                case (cfg_index)
                    CFG_MTU:       cfg_mirror.mtu_bytes       = cfg_data[13:0];
                    CFG_HEADER:    cfg_mirror.header_bytes    = cfg_data[6:0];
                    CFG_KIND:      cfg_mirror.payload_kind    = cfg_data[6:0];
                    CFG_SOURCE:    cfg_mirror.source_id       = cfg_data;
                    CFG_BASE:      cfg_mirror.stamp_base      = cfg_data;
                    CFG_DELAY:     cfg_mirror.delay_ticks     = cfg_data;
                    CFG_TICKS:     cfg_mirror.frame_ticks_q16 = cfg_data;
                    CFG_FIRST_SEQ: next_seq                   = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                note = frame_note_q.pop_front();
                segment_frame(s_tdata[18:0], s_tuser, frame_pkts);
                frames_in++;
                if (frame_pkts.size() == 0) empty_frames++;
                if (frame_pkts.size() == MAX_PACKETS) full_frames++;
                case (note.kind)
                    ROW_ONE:  packet_expect_q.push_back(note.pkt);
                    ROW_NONE: ;
                    default: begin
                        foreach (frame_pkts[i]) packet_expect_q.push_back(frame_pkts[i]);
                    end
                endcase
            end
            if (m_tvalid && m_tready) begin
                packets_out++;
                if (packet_expect_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected packet, expected none, got %h %h %b",
                             $time, m_tdata, m_tuser, m_tlast);
                end else begin
                    want = packet_expect_q.pop_front();
                    check_field("payload_bytes", 32'(want.payload_bytes), 32'(m_tdata[15:0]));
                    check_field("picture_code", 32'(want.picture_code), 32'(m_tuser));
                    check_field("marker", 32'(want.marker), 32'(m_tlast));
                    check_field("sequence_number", 32'(want.sequence_number),
                                32'(m_tdata[31:16]));
                    check_field("timestamp", want.timestamp, m_tdata[63:32]);
                    check_field("source_out", want.source_out, m_tdata[95:64]);
                    check_field("payload_type_out", 32'(want.payload_type_out),
                                32'(m_tdata[102:96]));
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles == LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, LIMIT);
            $display("tb NOT OK");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off on request
    initial begin : receiver
        int gap;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_requests != holds_done) begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            gap = $urandom_range(0, rx_gap_max);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_frame(input logic [18:0] bits, input logic [7:0] letter,
                              input row_kind_t kind, input pkt_t typed);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        frame_note_q.push_back('{kind, typed});
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, bits};
        s_tuser  <= letter;
        do @(posedge aclk); while (!s_tready);
    endtask

    // wait until every packet has arrived and the block is idle
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (packet_expect_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin : stimulus
        cfg_index_t  reg_sel;
        logic [31:0] value;
        logic [18:0] bits;
        logic [7:0]  letter;
        int          pick;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG) begin
                settle();
                write_reg(plan[i].idx, plan[i].value);
            end else begin
                send_frame(plan[i].bits, plan[i].letter, plan[i].kind, plan[i].pkt);
            end
        end

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            settle();
            tx_gap_max = (phase % 3 == 1) ? 0 : 5;
            rx_gap_max = (phase % 4 == 2) ? 0 : 5;
            reg_sel = reg_sel.first();
            do begin
                if ($urandom_range(0, 1) == 1) begin
                    value = $urandom;
                    case (reg_sel)
                        CFG_MTU: begin
                            if ($urandom_range(0, 3) != 0)
                                value[13:0] = 14'($urandom_range(MTU_LOW, MTU_HIGH));
                        end
                        CFG_HEADER: begin
                            if ($urandom_range(0, 3) != 0)
                                value[6:0] = 7'($urandom_range(0, HEADER_HIGH));
                        end
                        default: ;
                    endcase
                    write_reg(reg_sel, value);
                end
                reg_sel = reg_sel.next();
            end while (reg_sel != reg_sel.first());

            if (phase == 2) hold_requests++;
            for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
                if (phase == 5 && n == FRAMES_PER_PHASE / 2) settle();
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    bits = 19'($urandom_range(0, 15));
                else if (pick < 5)
                    bits = 19'($urandom_range(0, 40000));
                else if (pick < 8)
                    bits = 19'($urandom_range(0, 150000));
                else
                    bits = 19'($urandom);
                case ($urandom_range(0, 9))
                    0, 1: letter = "I";
                    2, 3: letter = "P";
                    4:    letter = "B";
                    5:    letter = "D";
                    default: letter = 8'($urandom);
                endcase
                send_frame(bits, letter, ROW_PREDICT, NO_PKT);
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("frames %0d (%0d without packets, %0d of %0d packets), packets %0d",
                 frames_in, empty_frames, full_frames, MAX_PACKETS, packets_out);
        $display("register writes %0d over %0d random phases, mismatches %0d",
                 cfg_writes, RANDOM_PHASES, errors);
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
